// ----- hw/rtl/ost_pkg.sv -----
// Shared widths, operation and status codes, and cell control type for the ordered set table.
package ost_pkg;

    localparam int FUNC_W     = 2;
    localparam int VALUE_W    = 32;
    localparam int POSITION_W = 7;
    localparam int COUNT_W    = 8;
    localparam int STATUS_W   = 2;
    localparam int SCAN_W     = 32;
    localparam int SCAN_IDX_W = 5;

    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_DUPLICATE = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd3;

    typedef logic [VALUE_W-1:0] value_t;

    typedef struct packed {
        logic valid;
        logic capture;
        logic load;
        logic shift;
    } cell_ctl_t;

endpackage

// ----- hw/rtl/ost_if.sv -----
// Request and response channel interfaces of the ordered set table.
interface ost_req_if;
    logic                              valid;
    logic                              ready;
    logic        [ost_pkg::FUNC_W-1:0] func;
    logic signed [ost_pkg::VALUE_W-1:0] value;

    modport source (output valid, func, value, input ready);
    modport sink (input valid, func, value, output ready);
endinterface

interface ost_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 found;
    logic [ost_pkg::POSITION_W-1:0]       position;
    logic [ost_pkg::COUNT_W-1:0]          count;
    logic [ost_pkg::STATUS_W-1:0]         status;

    modport source (output valid, found, position, count, status, input ready);
    modport sink (input valid, found, position, count, status, output ready);
endinterface

// ----- hw/rtl/ordered_set_table.sv -----
// Top level of the ordered set table: a chain of entry cells, the match scanner and the sequencer.
//
// Keeps up to CAPACITY distinct 32-bit values in insertion order. Each request
// (insert, remove or query) returns one response with found, position, count
// and status. A request passes through these steps in order: an accept step
// in which every cell compares its entry, a match scan that takes one
// 32-cell chunk of the cells at a time, a scan result step and an apply
// step that appends or shifts the cells and loads the response register. The
// apply step waits while the previous response is still stalled. A finished
// response waits in its own register, so the next request can be accepted
// while the previous response is pending.
module ordered_set_table import ost_pkg::*;
#(
    parameter int CAPACITY = 128
)
(
    input logic      clk,
    input logic      rst_n,
    ost_req_if.sink  req,
    ost_rsp_if.source rsp
);

    localparam int OCC_W = $clog2(CAPACITY + 1);
    localparam int POS_W = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_APPLY = 2'd2;

    logic [1:0]          state_reg;
    logic [1:0]          state_next;
    logic [OCC_W-1:0]    occ_reg;
    logic [OCC_W-1:0]    occ_next;
    logic [FUNC_W-1:0]   func_reg;
    value_t              value_reg;

    logic                out_valid_reg;
    logic                out_found_reg;
    logic [POSITION_W-1:0] out_pos_reg;
    logic [COUNT_W-1:0]  out_count_reg;
    logic [STATUS_W-1:0] out_status_reg;

    logic                req_fire;
    logic                out_free;
    logic                apply;
    logic                full;
    logic                do_insert;
    logic                do_remove;
    logic [STATUS_W-1:0] status_c;
    logic [OCC_W-1:0]    res_pos;
    logic [OCC_W-1:0]    pos_ext;

    logic                loc_done;
    logic                loc_found;
    logic [POS_W-1:0]    loc_pos;

    value_t              cell_value;
    value_t              cell_data [CAPACITY];
    logic [CAPACITY-1:0] match;
    cell_ctl_t           ctl [CAPACITY];

    assign req.ready  = (state_reg == ST_IDLE);
    assign req_fire   = req.valid && req.ready;
    assign out_free   = !out_valid_reg || rsp.ready;
    assign apply      = (state_reg == ST_APPLY) && out_free;
    assign cell_value = (state_reg == ST_IDLE) ? value_t'(req.value) : value_reg;
    assign full       = (occ_reg == OCC_W'(CAPACITY));
    assign pos_ext    = OCC_W'(loc_pos);

    always_comb
    begin
        do_insert = 1'b0;
        do_remove = 1'b0;
        occ_next  = occ_reg;
        res_pos   = loc_found ? pos_ext : '0;
        case (func_reg)
            FUNC_INSERT:
            begin
                if (full)
                begin
                    status_c = STATUS_FULL;
                end
                else if (loc_found)
                begin
                    status_c = STATUS_DUPLICATE;
                end
                else
                begin
                    status_c  = STATUS_OK;
                    do_insert = 1'b1;
                    res_pos   = occ_reg;
                    occ_next  = occ_reg + 1'b1;
                end
            end
            FUNC_REMOVE:
            begin
                if (loc_found)
                begin
                    status_c  = STATUS_OK;
                    do_remove = 1'b1;
                    occ_next  = occ_reg - 1'b1;
                end
                else
                begin
                    status_c = STATUS_NOT_FOUND;
                end
            end
            default:
            begin
                status_c = loc_found ? STATUS_OK : STATUS_NOT_FOUND;
            end
        endcase
    end

    always_comb
    begin
        case (state_reg)
            ST_IDLE:  state_next = req_fire ? ST_SCAN : ST_IDLE;
            ST_SCAN:  state_next = loc_done ? ST_APPLY : ST_SCAN;
            ST_APPLY: state_next = out_free ? ST_IDLE : ST_APPLY;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (apply)
            begin
                occ_reg       <= occ_next;
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            func_reg  <= req.func;
            value_reg <= value_t'(req.value);
        end
        if (apply)
        begin
            out_found_reg  <= loc_found;
            out_pos_reg    <= POSITION_W'(res_pos);
            out_count_reg  <= COUNT_W'(occ_next);
            out_status_reg <= status_c;
        end
    end

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        assign ctl[i].valid   = (OCC_W'(i) < occ_reg);
        assign ctl[i].capture = req_fire;
        assign ctl[i].load    = apply && do_insert && (OCC_W'(i) == occ_reg);
        assign ctl[i].shift   = apply && do_remove && (OCC_W'(i) >= pos_ext)
                                && (OCC_W'(i + 1) < occ_reg);

        if (i == CAPACITY - 1)
        begin : g_last
            ost_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctl       (ctl[i]),
                .value     (cell_value),
                .next_data ('0),
                .data      (cell_data[i]),
                .match     (match[i])
            );
        end
        else
        begin : g_mid
            ost_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctl       (ctl[i]),
                .value     (cell_value),
                .next_data (cell_data[i + 1]),
                .data      (cell_data[i]),
                .match     (match[i])
            );
        end
    end

    ost_locate #(
        .CAPACITY (CAPACITY),
        .POS_W    (POS_W)
    ) u_locate (
        .clk   (clk),
        .rst_n (rst_n),
        .start (req_fire),
        .match (match),
        .done  (loc_done),
        .found (loc_found),
        .pos   (loc_pos)
    );

    assign rsp.valid    = out_valid_reg;
    assign rsp.found    = out_found_reg;
    assign rsp.position = out_pos_reg;
    assign rsp.count    = out_count_reg;
    assign rsp.status   = out_status_reg;

endmodule

// ----- hw/rtl/ost_cell.sv -----
// One storage cell of the table: holds an entry, compares it, loads or takes its neighbor's entry.
module ost_cell import ost_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cell_ctl_t ctl,
    input  value_t    value,
    input  value_t    next_data,
    output value_t    data,
    output logic      match
);

    value_t data_reg;
    logic   match_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            data_reg <= value;
        end
        else if (ctl.shift)
        begin
            data_reg <= next_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else if (ctl.capture)
        begin
            match_reg <= ctl.valid && (data_reg == value);
        end
    end

    assign data  = data_reg;
    assign match = match_reg;

endmodule

// ----- hw/rtl/ost_locate.sv -----
// Scans the registered match vector a chunk per cycle and encodes the matching position.
module ost_locate import ost_pkg::*;
#(
    parameter int CAPACITY = 128,
    parameter int POS_W    = 7
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [CAPACITY-1:0] match,
    output logic                done,
    output logic                found,
    output logic [POS_W-1:0]    pos
);

    localparam int NCHUNK  = (CAPACITY + SCAN_W - 1) / SCAN_W;
    localparam int CHUNK_W = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
    localparam int PAD_W   = NCHUNK * SCAN_W;
    localparam int FULL_W  = CHUNK_W + SCAN_IDX_W;

    logic [PAD_W-1:0]      padded;
    logic [SCAN_W-1:0]     chunk;
    logic [SCAN_IDX_W-1:0] lo;
    logic                  hit;
    logic [FULL_W-1:0]     full_pos;

    logic                  busy_reg;
    logic [CHUNK_W-1:0]    chunk_reg;
    logic                  done_reg;
    logic                  found_reg;
    logic [POS_W-1:0]      pos_reg;

    assign padded = PAD_W'(match);
    assign chunk  = padded[chunk_reg * SCAN_W +: SCAN_W];

    always_comb
    begin
        lo = '0;
        for (int i = 0; i < SCAN_W; i++)
        begin
            if (chunk[i])
            begin
                lo = lo | SCAN_IDX_W'(i);
            end
        end
    end

    assign hit      = |chunk;
    assign full_pos = {chunk_reg, lo};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            chunk_reg <= '0;
            done_reg  <= 1'b0;
            found_reg <= 1'b0;
            pos_reg   <= '0;
        end
        else if (start)
        begin
            busy_reg  <= 1'b1;
            chunk_reg <= '0;
            done_reg  <= 1'b0;
            found_reg <= 1'b0;
            pos_reg   <= '0;
        end
        else if (busy_reg)
        begin
            if (hit)
            begin
                found_reg <= 1'b1;
                pos_reg   <= full_pos[POS_W-1:0];
            end
            if (chunk_reg == CHUNK_W'(NCHUNK - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            else
            begin
                chunk_reg <= chunk_reg + 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign done  = done_reg;
    assign found = found_reg;
    assign pos   = pos_reg;

endmodule

// ----- hw/rtl/ost_checker.sv -----
// Port-level checks of the ordered set table and their binding to the top level.
module ost_checker import ost_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  req_valid,
    input logic                  req_ready,
    input logic                  rsp_valid,
    input logic                  rsp_ready,
    input logic                  found,
    input logic [POSITION_W-1:0] position,
    input logic [COUNT_W-1:0]    count,
    input logic [STATUS_W-1:0]   status
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(found) && $stable(position)
            && $stable(count) && $stable(status))
        else $error("stalled response changed");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while the previous one is in progress");

    a_not_found: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == STATUS_NOT_FOUND) |-> !found && (position == '0))
        else $error("not-found response reports a match");

    a_duplicate: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == STATUS_DUPLICATE) |-> found)
        else $error("duplicate response without a match");

endmodule

bind ordered_set_table ost_checker u_ost_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .found     (rsp.found),
    .position  (rsp.position),
    .count     (rsp.count),
    .status    (rsp.status)
);

// ----- dv/testbench.sv -----
// Testbench for ordered_set_table: directed and random requests, checked against a local set model.
`timescale 1ns / 100ps

localparam int SET_CAPACITY = 128;

typedef struct packed {
    logic                             found;
    logic [ost_pkg::POSITION_W-1:0]   position;
    logic [ost_pkg::COUNT_W-1:0]      count;
    logic [ost_pkg::STATUS_W-1:0]     status;
} set_result_t;

class set_result_tracker;
    logic [ost_pkg::VALUE_W-1:0] held [SET_CAPACITY];
    int                          held_count;
    set_result_t                 pending_results [$];
    int                          failures;

    function new();
        held_count = 0;
        failures   = 0;
    endfunction

    function set_result_t apply_request(logic [ost_pkg::FUNC_W-1:0] func,
                                        logic [ost_pkg::VALUE_W-1:0] value);
        set_result_t r;
        int          slot;
        int          i;
        bit          hit;
        hit  = 1'b0;
        slot = 0;
        for (i = 0; i < held_count; i++)
        begin
            if (!hit && held[i] == value)
            begin
                hit  = 1'b1;
                slot = i;
            end
        end
        r.status = ost_pkg::STATUS_OK;
        case (func)
            ost_pkg::FUNC_INSERT:
            begin
                if (held_count >= SET_CAPACITY)
                    r.status = ost_pkg::STATUS_FULL;
                else if (hit)
                    r.status = ost_pkg::STATUS_DUPLICATE;
                else
                begin
                    slot             = held_count;
                    held[held_count] = value;
                    held_count++;
                end
            end
            ost_pkg::FUNC_REMOVE:
            begin
                if (hit)
                begin
                    for (i = slot; i + 1 < held_count; i++)
                        held[i] = held[i + 1];
                    held_count--;
                end
                else
                    r.status = ost_pkg::STATUS_NOT_FOUND;
            end
            default:
            begin
                if (!hit)
                    r.status = ost_pkg::STATUS_NOT_FOUND;
            end
        endcase
        r.found    = hit;
        r.position = slot[ost_pkg::POSITION_W-1:0];
        r.count    = held_count[ost_pkg::COUNT_W-1:0];
        return r;
    endfunction

    function void note_request(logic [ost_pkg::FUNC_W-1:0] func,
                               logic [ost_pkg::VALUE_W-1:0] value);
        pending_results.push_back(apply_request(func, value));
    endfunction

    function void report(string field, logic [31:0] exp_val, logic [31:0] act_val);
        failures++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, exp_val,
                 act_val);
    endfunction

    function void check_response(set_result_t got);
        set_result_t exp;
        if (pending_results.size() == 0)
        begin
            failures++;
            $display("%0t: unexpected response, expected none, actual %0h", $time, got);
        end
        else
        begin
            exp = pending_results.pop_front();
            if (got.found !== exp.found)
                report("found", 32'(exp.found), 32'(got.found));
            if (got.position !== exp.position)
                report("position", 32'(exp.position), 32'(got.position));
            if (got.count !== exp.count)
                report("count", 32'(exp.count), 32'(got.count));
            if (got.status !== exp.status)
                report("status", 32'(exp.status), 32'(got.status));
        end
    endfunction
endclass

module testbench;
    import ost_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 32;
    localparam int PHASES       = 9;
    localparam int PHASE_ITEMS  = 148;
    localparam int POOL_SIZE    = 32;

    logic clk;
    logic rst_n;

    ost_req_if req_ch ();
    ost_rsp_if rsp_ch ();

    ordered_set_table #(.CAPACITY(SET_CAPACITY)) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    set_result_tracker tracker;

    int          burst_left;
    int          idle_cycles;
    int          stall_mode;
    int          stall_span;
    int          k;
    int          phase;
    int          n;
    int          pick;
    logic [31:0] stall_pat;
    logic [31:0] pool [POOL_SIZE];

    int insert_pct [PHASES] = '{50, 95, 90, 35, 10, 60, 95, 20, 45};
    int remove_pct [PHASES] = '{30,  0,  5, 35, 85, 30,  0, 70, 45};
    int fresh_pct  [PHASES] = '{30, 80, 30, 20, 10, 30, 90, 10, 30};

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    task automatic send_item(input logic [FUNC_W-1:0] func, input logic [VALUE_W-1:0] value);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0)
            begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 48);
        end
        burst_left--;
        req_ch.valid <= 1'b1;
        req_ch.func  <= func;
        req_ch.value <= value;
        do
            @(posedge clk);
        while (!req_ch.ready);
    endtask

    function automatic logic [VALUE_W-1:0] pick_value(int fresh);
        int r;
        r = $urandom_range(0, 99);
        if (tracker.held_count > 0 && r < 45)
            return tracker.held[$urandom_range(0, tracker.held_count - 1)];
        if ($urandom_range(0, 99) < fresh)
            return $urandom;
        return pool[$urandom_range(0, POOL_SIZE - 1)];
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
                tracker.note_request(req_ch.func, req_ch.value);
            if (rsp_ch.valid && rsp_ch.ready)
                tracker.check_response({rsp_ch.found, rsp_ch.position, rsp_ch.count,
                                        rsp_ch.status});
        end
    end

    initial
    begin
        rsp_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall_mode = $urandom_range(0, 3);
            stall_pat  = $urandom;
            stall_span = $urandom_range(16, 96);
            for (k = 0; k < stall_span; k++)
            begin
                @(posedge clk);
                case (stall_mode)
                    0:       rsp_ch.ready <= 1'b1;
                    1:       rsp_ch.ready <= stall_pat[k % 32];
                    2:       rsp_ch.ready <= ($urandom_range(0, 7) != 0);
                    default: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    initial
    begin
        idle_cycles = 0;
        @(posedge rst_n);
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("testbench failed");
        $finish;
    end

    initial
    begin
        tracker      = new();
        burst_left   = 0;
        rst_n        <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.func  <= FUNC_INSERT;
        req_ch.value <= '0;
        pool[0] = 32'h0000_0000;
        pool[1] = 32'hFFFF_FFFF;
        pool[2] = 32'h8000_0000;
        pool[3] = 32'h7FFF_FFFF;
        for (k = 4; k < POOL_SIZE; k++)
            pool[k] = $urandom;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(FUNC_QUERY,  32'h0000_0000);
        send_item(FUNC_REMOVE, 32'h0000_0000);
        send_item(FUNC_INSERT, 32'h8000_0000);
        send_item(FUNC_INSERT, 32'h7FFF_FFFF);
        send_item(FUNC_INSERT, 32'h0000_0000);
        send_item(FUNC_INSERT, 32'hFFFF_FFFF);
        send_item(FUNC_INSERT, 32'h7FFF_FFFF);
        send_item(FUNC_QUERY,  32'h8000_0000);
        send_item(FUNC_SPARE,  32'h0000_0000);
        send_item(FUNC_SPARE,  32'h0000_0001);
        send_item(FUNC_REMOVE, 32'h7FFF_FFFF);
        send_item(FUNC_QUERY,  32'hFFFF_FFFF);
        send_item(FUNC_REMOVE, 32'h1234_5678);
        send_item(FUNC_REMOVE, 32'h8000_0000);
        send_item(FUNC_REMOVE, 32'hFFFF_FFFF);
        send_item(FUNC_INSERT, 32'h5555_5555);
        send_item(FUNC_INSERT, 32'hAAAA_AAAA);
        send_item(FUNC_QUERY,  32'h0000_0000);
        send_item(FUNC_REMOVE, 32'h0000_0000);
        send_item(FUNC_REMOVE, 32'h5555_5555);
        send_item(FUNC_REMOVE, 32'hAAAA_AAAA);
        send_item(FUNC_REMOVE, 32'hAAAA_AAAA);
        send_item(FUNC_INSERT, 32'h0000_0001);

        for (phase = 0; phase < PHASES; phase++)
        begin
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < insert_pct[phase])
                    send_item(FUNC_INSERT, pick_value(fresh_pct[phase]));
                else if (pick < insert_pct[phase] + remove_pct[phase])
                    send_item(FUNC_REMOVE, pick_value(fresh_pct[phase]));
                else
                    send_item(($urandom_range(0, 7) == 0) ? FUNC_SPARE : FUNC_QUERY,
                              pick_value(fresh_pct[phase]));
            end
        end
        req_ch.valid <= 1'b0;

        while (tracker.pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.failures == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end
endmodule
